@@ hw/rtl/lcsb_pkg.sv @@
package lcsb_pkg;

  localparam int unsigned TickBits = 32;

  localparam int unsigned ButtonGapMs  = 300;
  localparam int unsigned HandPollMs   = 150;
  localparam int unsigned FillPollMs   = 500;
  localparam int unsigned ServoPollMs  = 15;
  localparam int unsigned StartupMs    = 2000;
  localparam int unsigned HandNoneCm   = 999;
  localparam int unsigned HandFloorCm  = 2;
  localparam int unsigned HandCeilCm   = 400;
  localparam int unsigned FillNoEchoCm = 16;
  localparam int unsigned ServoMinUs   = 500;
  localparam int unsigned ServoMaxUs   = 2500;
  localparam int unsigned ServoRstUs   = 1500;
  localparam int unsigned FullPct      = 100;

  localparam int unsigned OpenToggles   = 4;
  localparam int unsigned OpenBeepMs    = 100;
  localparam int unsigned FullToggles   = 6;
  localparam int unsigned FullBeepMs    = 200;

  typedef enum logic [1:0] {
    LID_CLOSED = 2'd0,
    LID_HAND   = 2'd1,
    LID_BUTTON = 2'd2
  } lid_mode_e;

  typedef enum logic [2:0] {
    CFG_HAND_MIN    = 3'd0,
    CFG_HAND_NEAR   = 3'd1,
    CFG_OPEN_HOLD   = 3'd2,
    CFG_SERVO_STEP  = 3'd3,
    CFG_OPEN_PULSE  = 3'd4,
    CFG_CLOSED_PULSE = 3'd5
  } cfg_reg_e;

  // 100 - (d - 3) * 100 / 13, clamped; only 4..15 cm gives a partial level
  function automatic logic [6:0] fill_pct(input logic [9:0] d);
    logic [6:0] pct;
    pct = 7'd0;
    if (d < 10'd3) begin
      pct = 7'd100;
    end else if (d < 10'd16) begin
      case (d[3:0])
        4'd3:    pct = 7'd100;
        4'd4:    pct = 7'd93;
        4'd5:    pct = 7'd85;
        4'd6:    pct = 7'd77;
        4'd7:    pct = 7'd70;
        4'd8:    pct = 7'd62;
        4'd9:    pct = 7'd54;
        4'd10:   pct = 7'd47;
        4'd11:   pct = 7'd39;
        4'd12:   pct = 7'd31;
        4'd13:   pct = 7'd24;
        4'd14:   pct = 7'd16;
        4'd15:   pct = 7'd8;
        default: pct = 7'd0;
      endcase
    end
    return pct;
  endfunction

endpackage

@@ hw/rtl/lid_controller_with_slew_and_beeper.sv @@
// an input is registered in the input stage, then in the output register
// throughput: one item per cycle while the output is not stalled; an input stage
//   and an output register decouple the two channels, so one item is taken while
//   a result waits to be taken
// reset: asynchronous, active low; clears tick time, lid, fill and beeper state,
//   sets the servo to its rest pulse and loads the register defaults
module lid_controller_with_slew_and_beeper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        hand_echo_ok_i,
  input  logic [9:0]  hand_distance_cm_i,
  input  logic        fill_echo_ok_i,
  input  logic [9:0]  fill_distance_cm_i,
  input  logic        button_press_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] servo_pulse_us_o,
  output logic        lid_open_led_o,
  output logic        buzzer_on_o,
  output logic [6:0]  fill_percent_o,
  output logic        bin_full_o,
  output logic [1:0]  lid_mode_o
);
  import lcsb_pkg::*;

  typedef logic [TickBits-1:0] tick_t;

  // configuration
  logic [9:0]  hand_min_q, hand_near_q;
  logic [15:0] open_hold_q;
  logic [7:0]  servo_step_q;
  logic [11:0] open_pulse_q, closed_pulse_q;

  // input stage
  logic        s1_valid_q;
  logic        s1_hand_ok_q, s1_fill_ok_q, s1_button_q;
  logic [9:0]  s1_hand_cm_q, s1_fill_cm_q;

  // block state
  tick_t       tick_q, open_since_q, last_hand_q, last_fill_q;
  tick_t       last_servo_q, last_button_q, next_toggle_q;
  lid_mode_e   lid_q;
  logic [9:0]  hand_dist_q;
  logic [6:0]  fill_level_q;
  logic        full_q;
  logic [11:0] servo_q, target_q;
  logic [2:0]  toggles_q;
  logic [7:0]  beep_int_q;
  logic        buzzer_q;

  tick_t       open_since_d, last_hand_d, last_fill_d;
  tick_t       last_servo_d, last_button_d, next_toggle_d;
  lid_mode_e   lid_d;
  logic [9:0]  hand_dist_d;
  logic [6:0]  fill_level_d;
  logic        full_d;
  logic [11:0] servo_d, target_d;
  logic [2:0]  toggles_d;
  logic [7:0]  beep_int_d;
  logic        buzzer_d;

  // output register
  logic        out_valid_q;
  logic [11:0] out_servo_q;
  logic        out_buzzer_q, out_full_q;
  logic [6:0]  out_fill_q;
  lid_mode_e   out_lid_q;

  logic advance;
  logic in_xfer;

  function automatic logic [9:0] s1_fill_echo_sel(input logic ok, input logic [9:0] cm);
    return ok ? cm : 10'(FillNoEchoCm);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_xfer     = in_valid_i && !in_stall_o;

  always_comb begin
    tick_t       now;
    logic [9:0]  fill_d;
    logic [6:0]  pct;
    logic [12:0] pos_up;
    logic [11:0] pos_dn;
    now           = tick_q;
    open_since_d  = open_since_q;
    last_hand_d   = last_hand_q;
    last_fill_d   = last_fill_q;
    last_servo_d  = last_servo_q;
    last_button_d = last_button_q;
    next_toggle_d = next_toggle_q;
    lid_d         = lid_q;
    hand_dist_d   = hand_dist_q;
    fill_level_d  = fill_level_q;
    full_d        = full_q;
    servo_d       = servo_q;
    target_d      = target_q;
    toggles_d     = toggles_q;
    beep_int_d    = beep_int_q;
    buzzer_d      = buzzer_q;
    fill_d        = s1_fill_echo_sel(s1_fill_ok_q, s1_fill_cm_q);
    pct           = fill_pct(fill_d);

    // debounced button
    if (s1_button_q && (tick_t'(now - last_button_q) >= tick_t'(ButtonGapMs))) begin
      last_button_d = now;
      if (lid_q == LID_CLOSED) begin
        lid_d         = LID_BUTTON;
        target_d      = open_pulse_q;
        open_since_d  = now;
        toggles_d     = 3'(OpenToggles);
        beep_int_d    = 8'(OpenBeepMs);
        next_toggle_d = now;
      end
    end

    // hand poll, only while closed
    if ((tick_t'(now - last_hand_q) > tick_t'(HandPollMs)) && (lid_d == LID_CLOSED)) begin
      if (!s1_hand_ok_q || (s1_hand_cm_q <= 10'(HandFloorCm))
          || (s1_hand_cm_q > 10'(HandCeilCm))) begin
        hand_dist_d = 10'(HandNoneCm);
      end else begin
        hand_dist_d = s1_hand_cm_q;
      end
      last_hand_d = now;
    end

    // fill poll
    if (tick_t'(now - last_fill_q) > tick_t'(FillPollMs)) begin
      fill_level_d = pct;
      if (pct == 7'(FullPct)) begin
        if (!full_q) begin
          toggles_d     = 3'(FullToggles);
          beep_int_d    = 8'(FullBeepMs);
          next_toggle_d = now;
          full_d        = 1'b1;
        end
      end else begin
        full_d = 1'b0;
      end
      last_fill_d = now;
    end

    // lid
    if (lid_d == LID_CLOSED) begin
      if ((hand_dist_d >= hand_min_q) && (hand_dist_d < hand_near_q)
          && (now > tick_t'(StartupMs))) begin
        lid_d         = LID_HAND;
        target_d      = open_pulse_q;
        open_since_d  = now;
        toggles_d     = 3'(OpenToggles);
        beep_int_d    = 8'(OpenBeepMs);
        next_toggle_d = now;
      end
    end else if (tick_t'(now - open_since_d) > tick_t'(open_hold_q)) begin
      target_d    = closed_pulse_q;
      hand_dist_d = 10'(HandNoneCm);
      lid_d       = LID_CLOSED;
    end

    // servo slew, position stays within 500..2500 so the step down cannot wrap
    pos_up = {1'b0, servo_q} + {5'b0, servo_step_q};
    pos_dn = servo_q - {4'b0, servo_step_q};
    if (tick_t'(now - last_servo_q) > tick_t'(ServoPollMs)) begin
      if (servo_q < target_d) begin
        servo_d = (pos_up > 13'(ServoMaxUs)) ? 12'(ServoMaxUs) : pos_up[11:0];
      end else if (servo_q > target_d) begin
        servo_d = (pos_dn < 12'(ServoMinUs)) ? 12'(ServoMinUs) : pos_dn;
      end
      last_servo_d = now;
    end

    // beeper
    if (toggles_d != 3'd0) begin
      if (now >= next_toggle_d) begin
        buzzer_d      = !buzzer_q;
        toggles_d     = toggles_d - 3'd1;
        next_toggle_d = now + tick_t'(beep_int_d);
      end
    end else begin
      buzzer_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hand_min_q     <= 10'd3;
      hand_near_q    <= 10'd20;
      open_hold_q    <= 16'd10000;
      servo_step_q   <= 8'd20;
      open_pulse_q   <= 12'd500;
      closed_pulse_q <= 12'd1500;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HAND_MIN:     hand_min_q     <= cfg_data_i[9:0];
        CFG_HAND_NEAR:    hand_near_q    <= cfg_data_i[9:0];
        CFG_OPEN_HOLD:    open_hold_q    <= cfg_data_i;
        CFG_SERVO_STEP:   servo_step_q   <= cfg_data_i[7:0];
        CFG_OPEN_PULSE:   open_pulse_q   <= cfg_data_i[11:0];
        CFG_CLOSED_PULSE: closed_pulse_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_hand_ok_q <= hand_echo_ok_i;
      s1_hand_cm_q <= hand_distance_cm_i;
      s1_fill_ok_q <= fill_echo_ok_i;
      s1_fill_cm_q <= fill_distance_cm_i;
      s1_button_q  <= button_press_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q        <= '0;
      open_since_q  <= '0;
      last_hand_q   <= '0;
      last_fill_q   <= '0;
      last_servo_q  <= '0;
      last_button_q <= '0;
      next_toggle_q <= '0;
      lid_q         <= LID_CLOSED;
      hand_dist_q   <= '0;
      fill_level_q  <= '0;
      full_q        <= 1'b0;
      servo_q       <= 12'(ServoRstUs);
      target_q      <= 12'(ServoRstUs);
      toggles_q     <= '0;
      beep_int_q    <= '0;
      buzzer_q      <= 1'b0;
    end else if (advance) begin
      tick_q        <= tick_q + tick_t'(1);
      open_since_q  <= open_since_d;
      last_hand_q   <= last_hand_d;
      last_fill_q   <= last_fill_d;
      last_servo_q  <= last_servo_d;
      last_button_q <= last_button_d;
      next_toggle_q <= next_toggle_d;
      lid_q         <= lid_d;
      hand_dist_q   <= hand_dist_d;
      fill_level_q  <= fill_level_d;
      full_q        <= full_d;
      servo_q       <= servo_d;
      target_q      <= target_d;
      toggles_q     <= toggles_d;
      beep_int_q    <= beep_int_d;
      buzzer_q      <= buzzer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_servo_q  <= servo_d;
      out_buzzer_q <= buzzer_d;
      out_fill_q   <= fill_level_d;
      out_full_q   <= full_d;
      out_lid_q    <= lid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign servo_pulse_us_o = out_servo_q;
  assign lid_open_led_o   = (out_lid_q != LID_CLOSED);
  assign buzzer_on_o      = out_buzzer_q;
  assign fill_percent_o   = out_fill_q;
  assign bin_full_o       = out_full_q;
  assign lid_mode_o       = out_lid_q;

endmodule

@@ hw/rtl/lcsb_checker.sv @@
module lcsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] servo_pulse_us_o,
  input logic        lid_open_led_o,
  input logic [6:0]  fill_percent_o,
  input logic        bin_full_o,
  input logic [1:0]  lid_mode_o
);
  import lcsb_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(servo_pulse_us_o)
      && $stable(lid_mode_o) && $stable(fill_percent_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (servo_pulse_us_o >= 12'(ServoMinUs))
      && (servo_pulse_us_o <= 12'(ServoMaxUs)))
    else $error("servo pulse out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lid_open_led_o == (lid_mode_o != LID_CLOSED))
    else $error("lid led disagrees with lid mode");

  // the full flag follows the fill level as sampled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bin_full_o == (fill_percent_o == 7'(FullPct)))
    else $error("bin full flag disagrees with fill level");

endmodule

bind lid_controller_with_slew_and_beeper lcsb_checker u_lcsb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .servo_pulse_us_o (servo_pulse_us_o),
  .lid_open_led_o   (lid_open_led_o),
  .fill_percent_o   (fill_percent_o),
  .bin_full_o       (bin_full_o),
  .lid_mode_o       (lid_mode_o)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lcsb_pkg::*;

  localparam int unsigned PhaseItems = 50;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned NumRows    = 9;
  localparam int unsigned NumRegs    = 6;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic       hand_ok;
    logic [9:0] hand_cm;
    logic       fill_ok;
    logic [9:0] fill_cm;
    logic       button;
  } ms_tick_t;

  typedef struct packed {
    logic [11:0] servo_us;
    logic        led;
    logic        buzz;
    logic [6:0]  fill_pct;
    logic        full;
    lid_mode_e   mode;
  } lid_outputs_t;

  typedef struct {
    ms_tick_t     t;
    int unsigned  reps;
    bit           typed;
    lid_outputs_t want;
  } plan_row_t;

  localparam lid_outputs_t AtRest = '{12'd1500, 1'b0, 1'b0, 7'd0, 1'b0, LID_CLOSED};

  localparam logic [9:0] DistEdges [9] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd15, 10'd16,
                                           10'd400, 10'd401, 10'd1023};

  // hand polls land at 151, 302, 453 and 604, the first fill poll at 501
  plan_row_t plan [NumRows] = '{
    '{'{1'b0, 10'd0,    1'b0, 10'd0,    1'b0}, 1,   1'b1, AtRest},
    // press inside the debounce window right after reset
    '{'{1'b1, 10'd1023, 1'b1, 10'd1023, 1'b1}, 1,   1'b1, AtRest},
    '{'{1'b1, 10'd0,    1'b1, 10'd0,    1'b0}, 150, 1'b0, '0},
    '{'{1'b1, 10'd2,    1'b1, 10'd1,    1'b0}, 151, 1'b0, '0},
    '{'{1'b1, 10'd401,  1'b1, 10'd2,    1'b0}, 151, 1'b0, '0},
    // bin reads full here; a near hand inside the startup window must not open
    '{'{1'b1, 10'd3,    1'b1, 10'd2,    1'b0}, 151, 1'b0, '0},
    // button opens the lid, open beeps take over the full beeps
    '{'{1'b1, 10'd10,   1'b1, 10'd3,    1'b1}, 1,   1'b0, '0},
    '{'{1'b0, 10'd0,    1'b1, 10'd3,    1'b0}, 100, 1'b0, '0},
    // press inside the debounce window while open
    '{'{1'b1, 10'd12,   1'b1, 10'd9,    1'b1}, 1,   1'b0, '0}
  };

  // rows 4 and 6 are drawn at random
  logic [15:0] reg_plan [NumPhases][NumRegs] = '{
    '{16'd3,    16'd20,   16'd10000, 16'd20,  16'd500,  16'd1500},
    '{16'd0,    16'd1023, 16'd0,     16'd255, 16'd2500, 16'd500},
    '{16'd1023, 16'd0,    16'd65535, 16'd1,   16'd500,  16'd2500},
    '{16'd3,    16'd30,   16'd300,   16'd0,   16'd1700, 16'd1300},
    '{16'd0,    16'd0,    16'd0,     16'd0,   16'd0,    16'd0},
    '{16'd5,    16'd25,   16'd25,    16'd13,  16'd4095, 16'd0},
    '{16'd0,    16'd0,    16'd0,     16'd0,   16'd0,    16'd0},
    '{16'd2,    16'd400,  16'd40,    16'd7,   16'd2000, 16'd1000}
  };

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        hand_echo_ok_i = 1'b0;
  logic [9:0]  hand_distance_cm_i = '0;
  logic        fill_echo_ok_i = 1'b0;
  logic [9:0]  fill_distance_cm_i = '0;
  logic        button_press_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [11:0] servo_pulse_us_o;
  logic        lid_open_led_o;
  logic        buzzer_on_o;
  logic [6:0]  fill_percent_o;
  logic        bin_full_o;
  logic [1:0]  lid_mode_o;

  lid_controller_with_slew_and_beeper dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .hand_echo_ok_i     (hand_echo_ok_i),
    .hand_distance_cm_i (hand_distance_cm_i),
    .fill_echo_ok_i     (fill_echo_ok_i),
    .fill_distance_cm_i (fill_distance_cm_i),
    .button_press_i     (button_press_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .servo_pulse_us_o   (servo_pulse_us_o),
    .lid_open_led_o     (lid_open_led_o),
    .buzzer_on_o        (buzzer_on_o),
    .fill_percent_o     (fill_percent_o),
    .bin_full_o         (bin_full_o),
    .lid_mode_o         (lid_mode_o)
  );

  // register copies, reset values
  logic [9:0]  hand_min_cm = 10'd3;
  logic [9:0]  hand_near_cm = 10'd20;
  logic [15:0] hold_ms = 16'd10000;
  logic [7:0]  slew_us = 8'd20;
  logic [11:0] open_us = 12'd500;
  logic [11:0] closed_us = 12'd1500;

  // lid, servo, fill and beeper state
  logic [31:0] ms_now = '0;
  logic [31:0] opened_at = '0;
  logic [31:0] hand_polled_at = '0;
  logic [31:0] fill_polled_at = '0;
  logic [31:0] slewed_at = '0;
  logic [31:0] pressed_at = '0;
  logic [31:0] toggle_due = '0;
  lid_mode_e   lid = LID_CLOSED;
  logic [9:0]  hand_held = '0;
  int          servo_pos = 1500;
  int          servo_goal = 1500;
  logic [6:0]  fill_held = '0;
  logic        full_held = 1'b0;
  logic [2:0]  toggles_left = '0;
  logic [7:0]  beep_ms = '0;
  logic        buzz = 1'b0;

  lid_outputs_t lid_outputs_due [$];
  lid_outputs_t head;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned hand_opens = 0;
  int unsigned button_opens = 0;
  int unsigned closings = 0;
  int unsigned full_alarms = 0;
  int unsigned quiet_cycles = 0;

  function automatic void start_beeps(int unsigned toggles, int unsigned ms,
                                      logic [31:0] now);
    toggles_left = 3'(toggles);
    beep_ms = 8'(ms);
    toggle_due = now;
  endfunction

  function automatic void open_lid(lid_mode_e mode, logic [31:0] now);
    lid = mode;
    servo_goal = int'(open_us);
    opened_at = now;
    start_beeps(OpenToggles, OpenBeepMs, now);
    if (mode == LID_HAND) hand_opens++;
    else button_opens++;
  endfunction

  function automatic lid_outputs_t advance_one_ms(ms_tick_t t);
    logic [31:0]  now;
    logic [9:0]   d;
    int unsigned  q;
    logic [6:0]   pct;
    lid_outputs_t r;
    now = ms_now;

    if (t.button && (now - pressed_at) >= ButtonGapMs) begin
      pressed_at = now;
      if (lid == LID_CLOSED) open_lid(LID_BUTTON, now);
    end

    if ((now - hand_polled_at) > HandPollMs && lid == LID_CLOSED) begin
      if (!t.hand_ok || t.hand_cm <= HandFloorCm || t.hand_cm > HandCeilCm) begin
        hand_held = 10'(HandNoneCm);
      end else begin
        hand_held = t.hand_cm;
      end
      hand_polled_at = now;
    end

    if ((now - fill_polled_at) > FillPollMs) begin
      d = t.fill_ok ? t.fill_cm : 10'(FillNoEchoCm);
      if (d < 10'd3) begin
        pct = 7'(FullPct);
      end else begin
        // 3 cm is full, 16 cm is empty
        q = ((32'(d) - 3) * 100) / 13;
        pct = (q >= 100) ? 7'd0 : 7'(100 - q);
      end
      fill_held = pct;
      if (pct >= FullPct) begin
        if (!full_held) begin
          start_beeps(FullToggles, FullBeepMs, now);
          full_held = 1'b1;
          full_alarms++;
        end
      end else begin
        full_held = 1'b0;
      end
      fill_polled_at = now;
    end

    if (lid == LID_CLOSED) begin
      if (hand_held >= hand_min_cm && hand_held < hand_near_cm && now > StartupMs) begin
        open_lid(LID_HAND, now);
      end
    end else if ((now - opened_at) > 32'(hold_ms)) begin
      servo_goal = int'(closed_us);
      hand_held = 10'(HandNoneCm);
      lid = LID_CLOSED;
      closings++;
    end

    if ((now - slewed_at) > ServoPollMs) begin
      // a goal off the step grid makes the servo hunt around it
      if (servo_pos < servo_goal) servo_pos = servo_pos + int'(slew_us);
      else if (servo_pos > servo_goal) servo_pos = servo_pos - int'(slew_us);
      if (servo_pos < int'(ServoMinUs)) servo_pos = int'(ServoMinUs);
      if (servo_pos > int'(ServoMaxUs)) servo_pos = int'(ServoMaxUs);
      slewed_at = now;
    end

    if (toggles_left != 0) begin
      if (now >= toggle_due) begin
        buzz = ~buzz;
        toggles_left = toggles_left - 3'd1;
        toggle_due = now + 32'(beep_ms);
      end
    end else begin
      buzz = 1'b0;
    end

    r.servo_us = 12'(servo_pos);
    r.led = (lid != LID_CLOSED);
    r.buzz = buzz;
    r.fill_pct = fill_held;
    r.full = full_held;
    r.mode = lid;
    ms_now = ms_now + 32'd1;
    return r;
  endfunction

  // leaves valid high; the caller lowers it after the last write
  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    case (idx)
      CFG_HAND_MIN:     hand_min_cm = val[9:0];
      CFG_HAND_NEAR:    hand_near_cm = val[9:0];
      CFG_OPEN_HOLD:    hold_ms = val;
      CFG_SERVO_STEP:   slew_us = val[7:0];
      CFG_OPEN_PULSE:   open_us = val[11:0];
      CFG_CLOSED_PULSE: closed_us = val[11:0];
      default: ;
    endcase
  endtask

  task automatic send_tick(ms_tick_t t, bit typed, lid_outputs_t want);
    lid_outputs_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    hand_echo_ok_i <= t.hand_ok;
    hand_distance_cm_i <= t.hand_cm;
    fill_echo_ok_i <= t.fill_ok;
    fill_distance_cm_i <= t.fill_cm;
    button_press_i <= t.button;
    do @(posedge clk_i); while (in_stall_o);
    got = advance_one_ms(t);
    lid_outputs_due.push_back(typed ? want : got);
    ticks_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (lid_outputs_due.size() == 0) begin
        $display("%0t: result with nothing expected: servo %0d mode %0d", $time,
                 servo_pulse_us_o, lid_mode_o);
        errors++;
      end else begin
        head = lid_outputs_due.pop_front();
        if (servo_pulse_us_o !== head.servo_us) begin
          $display("%0t: servo_pulse_us expected %0d got %0d", $time, head.servo_us,
                   servo_pulse_us_o);
          errors++;
        end
        if (lid_open_led_o !== head.led) begin
          $display("%0t: lid_open_led expected %0b got %0b", $time, head.led,
                   lid_open_led_o);
          errors++;
        end
        if (buzzer_on_o !== head.buzz) begin
          $display("%0t: buzzer_on expected %0b got %0b", $time, head.buzz, buzzer_on_o);
          errors++;
        end
        if (fill_percent_o !== head.fill_pct) begin
          $display("%0t: fill_percent expected %0d got %0d", $time, head.fill_pct,
                   fill_percent_o);
          errors++;
        end
        if (bin_full_o !== head.full) begin
          $display("%0t: bin_full expected %0b got %0b", $time, head.full, bin_full_o);
          errors++;
        end
        if (lid_mode_o !== head.mode) begin
          $display("%0t: lid_mode expected %0d got %0d", $time, head.mode, lid_mode_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StuckLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    ms_tick_t    t;
    logic [15:0] vals [NumRegs];
    int unsigned pick;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      repeat (plan[r].reps) send_tick(plan[r].t, plan[r].typed, plan[r].want);
    end
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      while (lid_outputs_due.size() != 0) @(posedge clk_i);
      vals = reg_plan[ph];
      if (ph == 4 || ph == 6) begin
        vals[CFG_HAND_MIN] = 16'($urandom_range(0, 40));
        vals[CFG_HAND_NEAR] = 16'($urandom_range(0, 60));
        vals[CFG_OPEN_HOLD] = 16'($urandom_range(0, 600));
        vals[CFG_SERVO_STEP] = 16'($urandom_range(1, 255));
        vals[CFG_OPEN_PULSE] = 16'($urandom_range(ServoMinUs, ServoMaxUs));
        vals[CFG_CLOSED_PULSE] = 16'($urandom_range(ServoMinUs, ServoMaxUs));
      end
      for (int i = 0; i < NumRegs; i++) write_reg(cfg_reg_e'(i), vals[i]);
      cfg_valid_i <= 1'b0;

      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase

      repeat (PhaseItems) begin
        // mostly near hands and fill readings inside the partial band
        pick = $urandom_range(99);
        t.hand_ok = ($urandom_range(99) < 90);
        if (pick < 40) t.hand_cm = 10'($urandom_range(0, 40));
        else if (pick < 55) t.hand_cm = DistEdges[$urandom_range(0, 8)];
        else t.hand_cm = 10'($urandom);
        pick = $urandom_range(99);
        t.fill_ok = ($urandom_range(99) < 85);
        if (pick < 60) t.fill_cm = 10'($urandom_range(0, 18));
        else if (pick < 72) t.fill_cm = DistEdges[$urandom_range(0, 8)];
        else t.fill_cm = 10'($urandom);
        t.button = ($urandom_range(99) < 2);
        send_tick(t, 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    while (lid_outputs_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d ms ticks sent over %0d register settings, %0d results checked, %0d errors",
             ticks_sent, NumPhases + 1, results_checked, errors);
    $display("lid opened %0d times by hand and %0d by button, closed %0d times, bin full %0d times",
             hand_opens, button_opens, closings, full_alarms);
    if (errors == 0 && lid_outputs_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
